>>> hw/rtl/sle_pkg.sv
// shared types, codes and sizes of the sequential list engine
package sle_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 7;
	localparam int CMP_W    = (CNT_W + 1 > POS_W + 1) ? CNT_W + 1 : POS_W + 1;

	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_DELETE = 2'd1;
	localparam logic [1:0] FUNC_FIND   = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	typedef struct packed {
		logic [1:0]       func;
		logic [POS_W-1:0] position;
		logic [63:0]      entry_key;
		logic [63:0]      entry_payload;
	} sle_in_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [POS_W-1:0] found_position;
		logic [63:0]      out_key;
		logic [63:0]      out_payload;
		logic [POS_W-1:0] entry_count;
	} sle_out_t;

	typedef struct packed {
		logic [63:0] key;
		logic [63:0] payload;
	} sle_ent_t;

	// classified command handed from front to back
	typedef struct packed {
		logic [1:0]       func;
		logic [1:0]       status;
		logic [IDX_W-1:0] slot;
		logic [IDX_W-1:0] rd_start;
		logic [CNT_W-1:0] rd_len;
		logic [CNT_W-1:0] cnt_after;
		logic [63:0]      key;
		logic [63:0]      payload;
	} sle_cmd_t;

endpackage

>>> hw/rtl/sequential_list_engine.sv
// top level of the sequential list engine
// An ordered list of up to CAPACITY entries (64-bit key, 64-bit payload) kept in one
// single-port-write, single-port-read memory. Each input word is an insert at a 1-based
// position, a delete at a position, or a find by key; each gives exactly one result word
// with status, found position, the deleted or found entry and the entry count afterwards.
// The front checks positions against its own running count and queues a command, so
// input words are taken while the back is still busy or a result waits to be popped.
// The back moves entries one per cycle through the memory read port, whose registered
// data is written back one place over; a find stops at its first match.
// Entries never written read as anything, but only filled positions are ever read.
// There is no clearing pass after reset.
module sequential_list_engine import sle_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  sle_in_t  item,
	output logic     empty,
	input  logic     pop,
	output sle_out_t result
);

	// front to queue
	logic     cmd_push;
	sle_cmd_t cmd;

	// queue to back
	logic     q_full;
	logic     q_empty;
	logic     q_pop;
	sle_cmd_t q_data;

	// full follows the command queue only, so a waiting result blocks input only once the queue fills
	assign full = q_full;

	sle_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.q_full   (q_full),
		.cmd_push (cmd_push),
		.cmd      (cmd)
	);

	sle_cmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.empty   (q_empty)
	);

	// back end owns the list memory and the result register
	sle_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_data),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule

>>> hw/rtl/sle_front.sv
// front end: checks positions against the running count and builds commands
module sle_front import sle_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  sle_in_t  item,
	input  logic     q_full,
	output logic     cmd_push,
	output sle_cmd_t cmd
);

	logic [CNT_W-1:0] cnt_q;
	logic [CMP_W-1:0] pos_w;
	logic [CMP_W-1:0] cnt_w;
	logic [CMP_W-1:0] slot_w;
	logic [IDX_W-1:0] slot;

	assign cmd_push = push & ~q_full;
	assign pos_w    = CMP_W'(item.position);
	assign cnt_w    = CMP_W'(cnt_q);
	assign slot_w   = pos_w - CMP_W'(1);
	assign slot     = slot_w[IDX_W-1:0];

	always_comb begin
		cmd.func      = item.func;
		cmd.status    = ST_OK;
		cmd.slot      = slot;
		cmd.rd_start  = '0;
		cmd.rd_len    = '0;
		cmd.cnt_after = cnt_q;
		cmd.key       = item.entry_key;
		cmd.payload   = item.entry_payload;
		case (item.func)
			FUNC_INSERT: begin
				if (pos_w == '0 || pos_w > cnt_w + CMP_W'(1)) begin
					cmd.status = ST_BADPOS;
				end else if (cnt_q == CNT_W'(CAPACITY)) begin
					cmd.status = ST_FULL;
				end else begin
					// shift runs from the last entry down to the slot
					cmd.rd_start  = IDX_W'(cnt_q - CNT_W'(1));
					cmd.rd_len    = cnt_q - CNT_W'(slot);
					cmd.cnt_after = cnt_q + CNT_W'(1);
				end
			end
			FUNC_DELETE: begin
				if (pos_w == '0 || pos_w > cnt_w) begin
					cmd.status = ST_BADPOS;
				end else begin
					cmd.rd_start  = slot;
					cmd.rd_len    = cnt_q - CNT_W'(slot);
					cmd.cnt_after = cnt_q - CNT_W'(1);
				end
			end
			FUNC_FIND: begin
				cmd.rd_len = cnt_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd_push) begin
			cnt_q <= cmd.cnt_after;
		end
	end

endmodule

>>> hw/rtl/sle_cmd_queue.sv
// two-entry command queue between front and back
module sle_cmd_queue import sle_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_en,
	input  sle_cmd_t wr_data,
	output logic     full,
	input  logic     rd_en,
	output sle_cmd_t rd_data,
	output logic     empty
);

	sle_cmd_t   ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_wr;
	logic       do_rd;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			ent_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

>>> hw/rtl/sle_back.sv
// back end: list memory, shift and scan sequencer, result register
module sle_back import sle_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     q_empty,
	input  sle_cmd_t q_data,
	output logic     q_pop,
	input  logic     pop,
	output logic     empty,
	output sle_out_t result
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	sle_ent_t         mem [CAPACITY];
	logic [1:0]       state_q;
	sle_cmd_t         cmd_q;
	logic [IDX_W-1:0] rd_addr_q;
	logic [CNT_W-1:0] left_q;
	logic             pend_s1;
	logic [IDX_W-1:0] pend_addr_s1;
	sle_ent_t         mem_rdata_s1;
	logic [63:0]      cap_key_q;
	logic [63:0]      cap_pay_q;
	logic [CNT_W-1:0] found_q;
	sle_out_t         res_q;
	logic             res_valid_q;

	logic             running;
	logic             match;
	logic             capture;
	logic             shift_we;
	logic             final_we;
	logic             issue;
	logic             done;
	logic             res_load;
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	sle_ent_t         mem_wd;

	assign running = (state_q == S_RUN);
	assign q_pop   = (state_q == S_IDLE) && !q_empty;
	assign empty   = ~res_valid_q;
	assign result  = res_q;

	// reply handling for the read issued last cycle
	assign match   = running && pend_s1 && cmd_q.func == FUNC_FIND
	                 && mem_rdata_s1.key == cmd_q.key;
	assign capture = running && pend_s1 && cmd_q.func == FUNC_DELETE
	                 && pend_addr_s1 == cmd_q.slot;
	assign shift_we = running && pend_s1
	                  && (cmd_q.func == FUNC_INSERT
	                      || (cmd_q.func == FUNC_DELETE && pend_addr_s1 != cmd_q.slot));
	assign issue    = running && left_q != '0 && !match;
	assign done     = running && ((left_q == '0 && !pend_s1) || match);
	assign final_we = done && cmd_q.func == FUNC_INSERT && cmd_q.status == ST_OK;
	assign res_load = (state_q == S_FIN) && (!res_valid_q || pop);

	always_comb begin
		mem_we = shift_we | final_we;
		mem_wa = cmd_q.slot;
		mem_wd = '{key: cmd_q.key, payload: cmd_q.payload};
		if (shift_we) begin
			mem_wd = mem_rdata_s1;
			if (cmd_q.func == FUNC_INSERT) begin
				mem_wa = pend_addr_s1 + IDX_W'(1);
			end else begin
				mem_wa = pend_addr_s1 - IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (issue) begin
			mem_rdata_s1 <= mem[rd_addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pend_s1     <= 1'b0;
			res_valid_q <= 1'b0;
			left_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						left_q  <= q_data.rd_len;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (done) begin
						pend_s1 <= 1'b0;
						state_q <= S_FIN;
					end else begin
						pend_s1 <= issue;
						if (issue) begin
							left_q <= left_q - CNT_W'(1);
						end
					end
				end
				S_FIN: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q     <= q_data;
			rd_addr_q <= q_data.rd_start;
			cap_key_q <= '0;
			cap_pay_q <= '0;
			found_q   <= '0;
		end else begin
			if (issue) begin
				pend_addr_s1 <= rd_addr_q;
				if (cmd_q.func == FUNC_INSERT) begin
					rd_addr_q <= rd_addr_q - IDX_W'(1);
				end else begin
					rd_addr_q <= rd_addr_q + IDX_W'(1);
				end
			end
			if (capture || match) begin
				cap_key_q <= mem_rdata_s1.key;
				cap_pay_q <= mem_rdata_s1.payload;
			end
			if (match) begin
				found_q <= CNT_W'(pend_addr_s1) + CNT_W'(1);
			end
		end
		if (res_load) begin
			res_q.status         <= cmd_q.status;
			res_q.found_position <= POS_W'(found_q);
			res_q.out_key        <= cap_key_q;
			res_q.out_payload    <= cap_pay_q;
			res_q.entry_count    <= POS_W'(cmd_q.cnt_after);
		end
	end

	a_no_pend_outside_run: assert property (@(posedge clk) disable iff (!arst_n)
		!running |-> !pend_s1)
		else $error("read reply pending outside the run state");

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && issue |-> mem_wa != rd_addr_q)
		else $error("list memory written and read at the same entry");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		running |-> cmd_q.cnt_after <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	a_fin_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> state_q == S_FIN && !pend_s1)
		else $error("sequencer did not reach the finish state");

endmodule

>>> tb/sv/tb_sequential_list_engine.sv
// self-checking testbench of the sequential list engine: directed rows, then random phases
module tb_sequential_list_engine;
	import sle_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1_000_000;
	// idle time after the last expected result, in which any extra result word would be caught
	localparam int DRAIN_CYCLES = 2 * CAPACITY + 20;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_WORDS = 100;
	localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	// selector value with no operation behind it
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} list_mode_t;

	// one row of the directed part; want is only used where typed is set
	typedef struct {
		sle_in_t  cmd;
		bit       typed;
		sle_out_t want;
	} dir_row_t;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     push;
	logic     full;
	sle_in_t  item;
	logic     empty;
	logic     pop;
	sle_out_t result;

	sequential_list_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always #4 clk = ~clk;

	// shadow copy of the list, updated as each word is accepted
	logic [63:0] list_key [CAPACITY];
	logic [63:0] list_pay [CAPACITY];
	int          list_len;

	sle_out_t  expect_q [$];
	dir_row_t  dir_rows [$];
	int        errors;
	int        words_in;
	int        cycles;
	bit        reached_full;
	sle_out_t  want_word;

	// -------------------------------------------------------------------------
	// list predictor: applies one command word to the shadow list and returns
	// the result word the block must give for it
	// -------------------------------------------------------------------------
	function automatic sle_out_t apply_command(sle_in_t w);
		sle_out_t r;
		int       slot;
		int       pos;
		r = '0;
		pos = int'(w.position);
		slot = pos - 1;
		case (w.func)
			FUNC_INSERT: begin
				if (pos < 1 || pos > list_len + 1) begin
					r.status = ST_BADPOS;
				end else if (list_len >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					// open a hole at slot by moving the tail up, last entry first
					for (int k = list_len; k > slot; k--) begin
						list_key[k] = list_key[k - 1];
						list_pay[k] = list_pay[k - 1];
					end
					list_key[slot] = w.entry_key;
					list_pay[slot] = w.entry_payload;
					list_len++;
				end
			end
			FUNC_DELETE: begin
				if (pos < 1 || pos > list_len) begin
					r.status = ST_BADPOS;
				end else begin
					r.out_key = list_key[slot];
					r.out_payload = list_pay[slot];
					// close the hole by moving the tail down
					for (int k = slot; k + 1 < list_len; k++) begin
						list_key[k] = list_key[k + 1];
						list_pay[k] = list_pay[k + 1];
					end
					list_len--;
				end
			end
			FUNC_FIND: begin
				// first match wins, so duplicate keys report the lowest position
				for (int k = 0; k < list_len; k++) begin
					if (list_key[k] == w.entry_key) begin
						r.found_position = POS_W'(k + 1);
						r.out_key = list_key[k];
						r.out_payload = list_pay[k];
						break;
					end
				end
			end
			default: ; // unused selector leaves the list alone
		endcase
		r.entry_count = POS_W'(list_len);
		if (list_len == CAPACITY)
			reached_full = 1'b1;
		return r;
	endfunction

	// -------------------------------------------------------------------------
	// gaps: mostly none or short, now and then a long one
	// -------------------------------------------------------------------------
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [63:0] rand_word64();
		return {$urandom(), $urandom()};
	endfunction

	// key choice: existing keys so finds hit and duplicates appear, a small pool
	// of corner values, or fully random bits
	function automatic logic [63:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45 && list_len > 0)
			return list_key[$urandom_range(0, list_len - 1)];
		if (r < 65) begin
			case ($urandom_range(0, 3))
				0: return 64'd0;
				1: return ONES;
				2: return 64'h8000_0000_0000_0001;
				default: return 64'h0000_0000_0000_00A5;
			endcase
		end
		return rand_word64();
	endfunction

	// random command word shaped by the current phase of the list
	function automatic sle_in_t make_word(list_mode_t mode);
		sle_in_t w;
		int      r;
		int      p;
		w.entry_key = pick_key();
		w.entry_payload = rand_word64();
		r = $urandom_range(0, 99);
		case (mode)
			MODE_GROW:   w.func = (r < 80) ? FUNC_INSERT : (r < 85) ? FUNC_DELETE :
				(r < 97) ? FUNC_FIND : FUNC_UNUSED;
			MODE_SHRINK: w.func = (r < 15) ? FUNC_INSERT : (r < 80) ? FUNC_DELETE :
				(r < 97) ? FUNC_FIND : FUNC_UNUSED;
			default:     w.func = (r < 40) ? FUNC_INSERT : (r < 70) ? FUNC_DELETE :
				(r < 95) ? FUNC_FIND : FUNC_UNUSED;
		endcase
		r = $urandom_range(0, 99);
		if (r < 88 && w.func == FUNC_INSERT) begin
			p = $urandom_range(1, list_len + 1);
		end else if (r < 88 && w.func == FUNC_DELETE && list_len > 0) begin
			p = $urandom_range(1, list_len);
		end else if (r < 94) begin
			// zero, or just past the last entry (list_len + 1 is still valid for an insert)
			case ($urandom_range(0, 2))
				0: p = 0;
				1: p = list_len + 1;
				default: p = list_len + 2;
			endcase
		end else begin
			p = $urandom_range(0, 127);
		end
		w.position = POS_W'(p);
		return w;
	endfunction

	task automatic add_row(logic [1:0] f, int p, logic [63:0] k, logic [63:0] v,
			bit typed, sle_out_t want);
		dir_row_t row;
		row.cmd.func = f;
		row.cmd.position = POS_W'(p);
		row.cmd.entry_key = k;
		row.cmd.entry_payload = v;
		row.typed = typed;
		row.want = want;
		dir_rows.push_back(row);
	endtask

	// -------------------------------------------------------------------------
	// sender: offers one word, holds it until taken, and records its expectation
	// entered and left at a falling edge
	// -------------------------------------------------------------------------
	task automatic send_word(sle_in_t w, bit typed, sle_out_t want, int gap);
		sle_out_t model_out;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		item <= w;
		do @(posedge clk); while (full);
		// taken at this edge: the predictor must still run on typed rows to track state
		model_out = apply_command(w);
		expect_q.push_back(typed ? want : model_out);
		words_in++;
		@(negedge clk);
	endtask

	function automatic void check_field(string name, logic [63:0] exp, logic [63:0] act);
		if (exp !== act) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp, act);
			errors++;
		end
	endfunction

	// -------------------------------------------------------------------------
	// result checker: every popped word against the oldest expectation
	// -------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expect_q.size() == 0) begin
				$error("result word popped with no expectation waiting");
				errors++;
			end else begin
				want_word = expect_q.pop_front();
				check_field("status", 64'(want_word.status), 64'(result.status));
				check_field("found_position", 64'(want_word.found_position),
					64'(result.found_position));
				check_field("out_key", want_word.out_key, result.out_key);
				check_field("out_payload", want_word.out_payload, result.out_payload);
				check_field("entry_count", 64'(want_word.entry_count),
					64'(result.entry_count));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// -------------------------------------------------------------------------
	// receiver: random pop runs and stalls, plus one long hold-off early in the
	// random part so the command queue fills and full backs up the sender
	// -------------------------------------------------------------------------
	initial begin
		int  run_left;
		int  stall_left;
		bit  held;
		pop = 1'b0;
		run_left = 0;
		stall_left = 0;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!held && dir_rows.size() > 0 && words_in >= dir_rows.size() + 30) begin
				held = 1'b1;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				if (run_left <= 0) begin
					run_left = $urandom_range(1, 40);
					stall_left = pick_gap();
				end else begin
					run_left--;
				end
			end
		end
	end

	// -------------------------------------------------------------------------
	// main sequence
	// -------------------------------------------------------------------------
	initial begin
		list_mode_t modes [8];
		int         n;
		bit         no_gaps;
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		errors = 0;
		words_in = 0;
		cycles = 0;
		list_len = 0;
		reached_full = 1'b0;

		// directed rows: typed expectations only where obvious
		add_row(FUNC_DELETE, 1, 64'd0, 64'd0, 1, '{ST_BADPOS, 7'd0, 64'd0, 64'd0, 7'd0});
		add_row(FUNC_FIND, 0, 64'd0, 64'd0, 1, '{ST_OK, 7'd0, 64'd0, 64'd0, 7'd0});
		add_row(FUNC_INSERT, 0, ONES, ONES, 1, '{ST_BADPOS, 7'd0, 64'd0, 64'd0, 7'd0});
		add_row(FUNC_INSERT, 2, ONES, ONES, 1, '{ST_BADPOS, 7'd0, 64'd0, 64'd0, 7'd0});
		add_row(FUNC_INSERT, 127, ONES, ONES, 1, '{ST_BADPOS, 7'd0, 64'd0, 64'd0, 7'd0});
		add_row(FUNC_INSERT, 1, ONES, ONES, 1, '{ST_OK, 7'd0, 64'd0, 64'd0, 7'd1});
		add_row(FUNC_INSERT, 1, 64'd0, 64'd0, 1, '{ST_OK, 7'd0, 64'd0, 64'd0, 7'd2});
		add_row(FUNC_INSERT, 3, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1,
			'{ST_OK, 7'd0, 64'd0, 64'd0, 7'd3});
		add_row(FUNC_FIND, 0, ONES, 64'd0, 1, '{ST_OK, 7'd2, ONES, ONES, 7'd3});
		// middle insert, then a duplicate key at the head
		add_row(FUNC_INSERT, 2, 64'hA5A5_A5A5_5A5A_5A5A, 64'h5555_AAAA_5555_AAAA, 0, '0);
		add_row(FUNC_INSERT, 1, ONES, 64'h0000_0000_0000_5555, 0, '0);
		add_row(FUNC_FIND, 0, ONES, 64'd0, 0, '0);
		add_row(FUNC_FIND, 0, 64'd1, 64'd0, 0, '0);
		// unused selector with every input bit set
		add_row(FUNC_UNUSED, 127, ONES, ONES, 1, '{ST_OK, 7'd0, 64'd0, 64'd0, 7'd5});
		add_row(FUNC_DELETE, 0, 64'd0, 64'd0, 1, '{ST_BADPOS, 7'd0, 64'd0, 64'd0, 7'd5});
		add_row(FUNC_DELETE, 6, 64'd0, 64'd0, 1, '{ST_BADPOS, 7'd0, 64'd0, 64'd0, 7'd5});
		add_row(FUNC_DELETE, 127, 64'd0, 64'd0, 1, '{ST_BADPOS, 7'd0, 64'd0, 64'd0, 7'd5});
		// delete last, first, then middle
		add_row(FUNC_DELETE, 5, 64'd0, 64'd0, 0, '0);
		add_row(FUNC_DELETE, 1, 64'd0, 64'd0, 0, '0);
		add_row(FUNC_DELETE, 2, 64'd0, 64'd0, 0, '0);
		add_row(FUNC_INSERT, 4, 64'd7, 64'd7, 1, '{ST_BADPOS, 7'd0, 64'd0, 64'd0, 7'd2});
		add_row(FUNC_FIND, 0, 64'd0, 64'd0, 0, '0);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_word(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want, pick_gap());

		// random phases: fill to capacity and beyond, drain past empty, and mix
		modes = '{MODE_GROW, MODE_SHRINK, MODE_MIXED, MODE_GROW,
			MODE_MIXED, MODE_SHRINK, MODE_GROW, MODE_SHRINK};
		foreach (modes[ph]) begin
			no_gaps = (ph % 3 == 2);
			n = 0;
			// the first grow phase keeps going until the list has been full, up to three times its usual word count
			while (n < PHASE_WORDS || (ph == 0 && !reached_full && n < 3 * PHASE_WORDS)) begin
				send_word(make_word(modes[ph]), 1'b0, '0, no_gaps ? 0 : pick_gap());
				n++;
			end
		end
		push <= 1'b0;

		wait (expect_q.size() == 0);
		// anything the block still produces now is an unexpected word
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expect_q.size() != 0) begin
			$error("%0d expected result words never arrived", expect_q.size());
			errors++;
		end
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> sequential_list_engine.f
hw/rtl/sle_pkg.sv
hw/rtl/sle_front.sv
hw/rtl/sle_cmd_queue.sv
hw/rtl/sle_back.sv
hw/rtl/sequential_list_engine.sv
tb/sv/tb_sequential_list_engine.sv
